[design/scsf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stereo crossfeed sample formatter.
// No dependencies; the top level refers to these by scoped names.
package scsf_pkg;

    localparam int SAMPLE_IN_W  = 32;
    localparam int PREC_W       = 5;
    localparam int S_TDATA_W    = 72;
    localparam int SAMPLE_OUT_W = 16;
    localparam int MIX_W        = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int QUOT_W       = 24;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_MIX_PERCENT  = 2'd0;
    localparam cfg_index_t REG_WIDE_SAMPLES = 2'd1;
    localparam cfg_index_t REG_STEREO_OUT   = 2'd2;

    // Smallest precision honored; anything below is treated as this.
    localparam logic [PREC_W-1:0] PREC_MIN       = 5'd8;
    localparam logic [PREC_W-1:0] PREC_MONO_WIDE = 5'd15;
    localparam logic [PREC_W-1:0] PREC_STEREO_W  = 5'd16;
    localparam logic [PREC_W-1:0] PREC_MONO_NARR = 5'd7;
    localparam logic [PREC_W-1:0] PREC_TOP       = 5'd31;

    localparam logic [PREC_W-1:0] SHIFT_WIDE   = 5'd16;
    localparam logic [PREC_W-1:0] SHIFT_NARROW = 5'd24;

    // percent * 2^21 / 25 = percent * 83886 + floor(percent * 2 / 25);
    // the small remainder term is percent * 82 >> 10, exact for 7-bit percent.
    localparam int Q21_INT        = 83886;
    localparam int Q21_FRAC       = 82;
    localparam int Q21_FRAC_SHIFT = 10;

    localparam logic [7:0] OFFSET_BINARY = 8'd128;

    // Per-item working values between the math stage and the output stage.
    typedef struct packed {
        logic                   mix;
        logic                   two;
        logic [SAMPLE_IN_W-1:0] x;
        logic [SAMPLE_IN_W-1:0] y;
    } prod_t;

endpackage

[design/stereo_crossfeed_sample_formatter.sv]
`timescale 1ns / 1ps
// Stereo crossfeed sample formatter: crossfeed mix and device-format conversion.
// Depends on scsf_pkg for constants and the stage struct.
//
// Usage:
//   s_ channel: one transaction per left/right pair. s_tdata carries left_in,
//   right_in and precision. m_ channel: one transaction per device sample;
//   m_tuser marks the right channel, m_tlast the final sample of a pair.
//   cfg_ channel: register writes (index, data), taken in any cycle; write only
//   while no pair is in flight.
// Path: a pair accepted on s_ passes the input, math and output registers,
//   in that order, before its first sample shows on m_.
// Throughput: the output register sends one sample per cycle while m_tready is
//   high and sets the pace; stereo gives two samples per pair, so it takes a
//   new pair only once both have gone, and mono gives one pair per cycle.
// Reset: pipeline empties, mix_percent goes to 0, wide_samples and
//   stereo_out to 1.
// Stall: while m_tready is low the output register holds; the math and input
//   registers still fill, so up to two more pairs are taken before s_tready
//   drops.
module stereo_crossfeed_sample_formatter (
    input  logic                               aclk,
    input  logic                               aresetn,
    // left_in [31:0], right_in [63:32], precision [68:64], zero pad [71:69]
    input  logic [scsf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_out [15:0]
    output logic [scsf_pkg::SAMPLE_OUT_W-1:0]  m_tdata,
    // is_right [0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [scsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic [scsf_pkg::MIX_W-1:0] mix_percent_reg, mix_percent_next;
    logic                       wide_samples_reg, wide_samples_next;
    logic                       stereo_out_reg, stereo_out_next;

    // pipeline
    logic [scsf_pkg::S_TDATA_W-1:0]    in_data_reg, in_data_next;
    logic                              in_valid_reg, in_valid_next;
    scsf_pkg::prod_t                   prod_reg, prod_next;
    logic                              prod_valid_reg, prod_valid_next;
    logic [scsf_pkg::SAMPLE_OUT_W-1:0] out0_reg, out0_next;
    logic [scsf_pkg::SAMPLE_OUT_W-1:0] out1_reg, out1_next;
    logic                              two_reg, two_next;
    logic                              beat_reg, beat_next;
    logic                              out_valid_reg, out_valid_next;

    logic in_fire, rdy_in, rdy_prod, rdy_out, out_last, out_fire, load_prod, load_out;

    // math stage signals
    logic [scsf_pkg::SAMPLE_IN_W-1:0] l_in, r_in, sum, diff;
    logic [scsf_pkg::PREC_W-1:0]      prec_raw, n_c;
    logic [scsf_pkg::SAMPLE_IN_W-1:0] mono_v, a_v, b_v, pp, quot, pm, prod_mul;
    logic [scsf_pkg::QUOT_W-1:0]      q21_reg, q21_next;
    logic [13:0]                      frac_prod;

    // output stage signals
    logic [scsf_pkg::SAMPLE_IN_W-1:0] t_a, t_b, sel0, sel1;
    logic [scsf_pkg::PREC_W-1:0]      out_shift;

    assign cfg_ready = 1'b1;

    always_comb begin
        mix_percent_next  = mix_percent_reg;
        wide_samples_next = wide_samples_reg;
        stereo_out_next   = stereo_out_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                scsf_pkg::REG_MIX_PERCENT:  mix_percent_next  = cfg_data;
                scsf_pkg::REG_WIDE_SAMPLES: wide_samples_next = cfg_data[0];
                scsf_pkg::REG_STEREO_OUT:   stereo_out_next   = cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake chain
    assign out_last  = !two_reg || beat_reg;
    assign out_fire  = out_valid_reg && m_tready;
    assign rdy_out   = !out_valid_reg || (m_tready && out_last);
    assign rdy_prod  = !prod_valid_reg || rdy_out;
    assign rdy_in    = !in_valid_reg || rdy_prod;
    assign s_tready  = rdy_in;
    assign in_fire   = s_tvalid && rdy_in;
    assign load_prod = in_valid_reg && rdy_prod;
    assign load_out  = prod_valid_reg && rdy_out;

    // percent * 2^21 / 25, floor, held alongside mix_percent; shifting it right
    // by n-8 gives the side term offset for every precision from 8 to 31.
    assign frac_prod = {7'd0, mix_percent_next} * 14'(scsf_pkg::Q21_FRAC);
    assign q21_next  = ({17'd0, mix_percent_next} * 24'(scsf_pkg::Q21_INT))
                     + 24'(frac_prod >> scsf_pkg::Q21_FRAC_SHIFT);

    always_comb begin
        l_in     = in_data_reg[31:0];
        r_in     = in_data_reg[63:32];
        prec_raw = in_data_reg[68:64];
        n_c      = (prec_raw < scsf_pkg::PREC_MIN) ? scsf_pkg::PREC_MIN : prec_raw;
        sum      = l_in + r_in;
        diff     = l_in - r_in;

        if (wide_samples_reg) begin
            mono_v = (n_c < scsf_pkg::PREC_MONO_WIDE) ?
                     (sum << (scsf_pkg::PREC_MONO_WIDE - n_c)) :
                     (sum >> (n_c - scsf_pkg::PREC_MONO_WIDE));
            if (n_c < scsf_pkg::PREC_STEREO_W) begin
                a_v = l_in << (scsf_pkg::PREC_STEREO_W - n_c);
                b_v = r_in << (scsf_pkg::PREC_STEREO_W - n_c);
            end else begin
                a_v = l_in >> (n_c - scsf_pkg::PREC_STEREO_W);
                b_v = r_in >> (n_c - scsf_pkg::PREC_STEREO_W);
            end
        end else begin
            mono_v = sum >> (n_c - scsf_pkg::PREC_MONO_NARR);
            a_v    = l_in >> (n_c - scsf_pkg::PREC_MIN);
            b_v    = r_in >> (n_c - scsf_pkg::PREC_MIN);
        end

        pp       = 32'd1 << (scsf_pkg::PREC_TOP - n_c);
        quot     = {8'd0, q21_reg} >> (n_c - scsf_pkg::PREC_MIN);
        pm       = pp - quot;
        prod_mul = diff * pm;

        prod_next = prod_reg;
        if (load_prod) begin
            prod_next.two = stereo_out_reg;
            prod_next.mix = stereo_out_reg && (mix_percent_reg != '0);
            if (!stereo_out_reg) begin
                prod_next.x = mono_v;
                prod_next.y = '0;
            end else if (mix_percent_reg == '0) begin
                prod_next.x = a_v;
                prod_next.y = b_v;
            end else begin
                prod_next.x = sum << (scsf_pkg::PREC_TOP - n_c);
                prod_next.y = prod_mul;
            end
        end
    end

    always_comb begin
        t_a       = prod_reg.x + prod_reg.y;
        t_b       = prod_reg.x - prod_reg.y;
        out_shift = wide_samples_reg ? scsf_pkg::SHIFT_WIDE : scsf_pkg::SHIFT_NARROW;
        sel0      = prod_reg.mix ? (t_a >> out_shift) : prod_reg.x;
        sel1      = prod_reg.mix ? (t_b >> out_shift) : prod_reg.y;

        out0_next = out0_reg;
        out1_next = out1_reg;
        two_next  = two_reg;
        if (load_out) begin
            two_next  = prod_reg.two;
            out0_next = wide_samples_reg ? sel0[15:0] :
                        {8'd0, sel0[7:0] + scsf_pkg::OFFSET_BINARY};
            out1_next = wide_samples_reg ? sel1[15:0] :
                        {8'd0, sel1[7:0] + scsf_pkg::OFFSET_BINARY};
        end
    end

    always_comb begin
        in_data_next    = in_fire ? s_tdata : in_data_reg;
        in_valid_next   = in_fire || (in_valid_reg && !rdy_prod);
        prod_valid_next = load_prod || (prod_valid_reg && !rdy_out);
        out_valid_next  = load_out || (out_valid_reg && !(m_tready && out_last));
        // advance to the right sample after the left transaction
        if (load_out) begin
            beat_next = 1'b0;
        end else if (out_fire && !out_last) begin
            beat_next = 1'b1;
        end else begin
            beat_next = beat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_percent_reg  <= '0;
            wide_samples_reg <= 1'b1;
            stereo_out_reg   <= 1'b1;
            q21_reg          <= '0;
            in_valid_reg     <= 1'b0;
            prod_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            beat_reg         <= 1'b0;
            two_reg          <= 1'b0;
        end else begin
            mix_percent_reg  <= mix_percent_next;
            wide_samples_reg <= wide_samples_next;
            stereo_out_reg   <= stereo_out_next;
            q21_reg          <= q21_next;
            in_valid_reg     <= in_valid_next;
            prod_valid_reg   <= prod_valid_next;
            out_valid_reg    <= out_valid_next;
            beat_reg         <= beat_next;
            two_reg          <= two_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        prod_reg    <= prod_next;
        out0_reg    <= out0_next;
        out1_reg    <= out1_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = beat_reg ? out1_reg : out0_reg;
    assign m_tuser  = beat_reg;
    assign m_tlast  = out_last;

    // the right sample only exists for a stereo pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && beat_reg |-> two_reg)
        else $error("right-channel beat on a mono result");

    // a left transaction is always followed by its right one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser && m_tlast)
        else $error("left sample not followed by right sample");

    // input backpressure only when every stage holds an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && prod_valid_reg && out_valid_reg)
        else $error("input stalled with an empty stage");

    // crossfeed math is only selected for stereo pairs
    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid_reg && prod_reg.mix |-> prod_reg.two)
        else $error("crossfeed selected in mono");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for stereo_crossfeed_sample_formatter: random stream traffic with
// stalls on both sides, results checked against an in-bench crossfeed predictor.
// Depends on scsf_pkg and the design top level.
module testbench;

    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_PAIRS    = 125;
    localparam int DIRECTED_SETS  = 5;
    localparam int DIRECTED_PAIRS = 5;

    typedef struct packed {
        logic [15:0] sample;
        logic        right;
        logic        last;
    } device_sample_t;

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic [scsf_pkg::S_TDATA_W-1:0]         s_tdata = '0;
    logic                                   s_tvalid = 1'b0;
    logic                                   s_tready;
    logic [scsf_pkg::SAMPLE_OUT_W-1:0]      m_tdata;
    logic                                   m_tuser;
    logic                                   m_tlast;
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [scsf_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [scsf_pkg::CFG_DATA_W-1:0]        cfg_data = '0;

    // register copies used by the predictor
    logic [6:0] cur_mix = 7'd0;
    logic       cur_wide = 1'b1;
    logic       cur_stereo = 1'b1;

    logic [scsf_pkg::S_TDATA_W-1:0] pair_queue[$];
    device_sample_t                 expected_samples[$];

    bit idle_on = 1'b1;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_cnt = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int pairs_sent = 0;
    int samples_checked = 0;
    int settings_count = 1;

    stereo_crossfeed_sample_formatter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] fit_to_precision(input logic [31:0] raw, input int bits);
        logic [31:0] up;
        up = raw << (32 - bits);
        return $unsigned($signed(up) >>> (32 - bits));
    endfunction

    function automatic logic [31:0] edge_sample();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [6:0] edge_mix();
        case ($urandom_range(0, 8))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd24;
            3:       return 7'd25;
            4:       return 7'd99;
            5:       return 7'd100;
            6:       return 7'd101;
            7:       return 7'd126;
            default: return 7'd127;
        endcase
    endfunction

    // Most pairs fit their precision; the rest are full-width noise or rail values.
    function automatic logic [scsf_pkg::S_TDATA_W-1:0] random_pair();
        logic [4:0]  prec;
        logic [31:0] l;
        logic [31:0] r;
        int          bits;
        int          kind;
        prec = ($urandom_range(0, 99) < 8) ? 5'($urandom_range(0, 7))
                                           : 5'($urandom_range(8, 31));
        bits = (prec < 5'd8) ? 8 : int'(prec);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            l = fit_to_precision($urandom, bits);
            r = fit_to_precision($urandom, bits);
        end else if (kind < 90) begin
            l = $urandom;
            r = $urandom;
        end else begin
            l = edge_sample();
            r = edge_sample();
        end
        return {3'b000, prec, r, l};
    endfunction

    function automatic logic [scsf_pkg::S_TDATA_W-1:0] directed_pair(input int idx);
        case (idx)
            0:       return {3'b000, 5'd31, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            1:       return {3'b000, 5'd8,  32'h8000_0000, 32'h8000_0000};
            2:       return {3'b000, 5'd0,  32'h8000_0000, 32'h7FFF_FFFF};
            3:       return {3'b000, 5'd15, 32'h0000_0001, 32'hFFFF_FFFF};
            default: return {3'b000, 5'd29, 32'h9ABC_DEF0, 32'h1234_5678};
        endcase
    endfunction

    function automatic void push_sample(input logic [31:0] v, input logic right,
                                        input logic last);
        device_sample_t s;
        s.sample = cur_wide ? v[15:0] : {8'h00, v[7:0] + 8'd128};
        s.right  = right;
        s.last   = last;
        expected_samples.push_back(s);
    endfunction

    function automatic void predict_device_samples(input logic [scsf_pkg::S_TDATA_W-1:0] pair);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] sum;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pp;
        logic [31:0] scaled;
        logic [31:0] pm;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [4:0]  n;
        int          sh;
        l = pair[31:0];
        r = pair[63:32];
        n = pair[68:64];
        if (n < 5'd8) n = 5'd8;
        sum = l + r;
        if (!cur_stereo) begin
            if (cur_wide) a = (n < 5'd15) ? sum << (15 - n) : sum >> (n - 15);
            else          a = sum >> (n - 7);
            push_sample(a, 1'b0, 1'b1);
        end else begin
            if (cur_mix == 7'd0) begin
                if (cur_wide) begin
                    a = (n < 5'd16) ? l << (16 - n) : l >> (n - 16);
                    b = (n < 5'd16) ? r << (16 - n) : r >> (n - 16);
                end else begin
                    a = l >> (n - 8);
                    b = r >> (n - 8);
                end
            end else begin
                pp     = 32'd1 << (31 - n);
                scaled = (n < 5'd29) ? 32'(cur_mix) << (29 - n) : 32'(cur_mix) >> (n - 29);
                pm     = pp - scaled / 32'd25;
                s1     = sum * pp;
                s2     = (l - r) * pm;
                sh     = cur_wide ? 16 : 24;
                a      = (s1 + s2) >> sh;
                b      = (s1 - s2) >> sh;
            end
            push_sample(a, 1'b0, 1'b0);
            push_sample(b, 1'b1, 1'b1);
        end
    endfunction

    // Sender: one pair per transaction, random gaps after each one while idle_on is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_device_samples(s_tdata);
                pairs_sent <= pairs_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pair_queue.size() > 0) begin
                    s_tdata  <= pair_queue.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap   <= idle_on ? gap_len() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each sample transaction, then decide the next ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
            hold_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                samples_checked <= samples_checked + 1;
                if (expected_samples.size() == 0) begin
                    error_count <= error_count + 1;
                    $display("%0t: unexpected sample, expected none, %s %h right %0b last %0b",
                             $time, "got data", m_tdata, m_tuser, m_tlast);
                end else begin
                    device_sample_t want;
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.sample || m_tuser !== want.right
                            || m_tlast !== want.last) begin
                        error_count <= error_count + 1;
                        $display("%0t: sample mismatch, expected data %h right %0b last %0b,",
                                 $time, want.sample, want.right, want.last);
                        $display("%0t:   got data %h right %0b last %0b",
                                 $time, m_tdata, m_tuser, m_tlast);
                    end
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_cnt <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap   <= idle_on ? gap_len() : 0;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("stereo_crossfeed_sample_formatter test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input scsf_pkg::cfg_index_t idx, input logic [6:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            scsf_pkg::REG_MIX_PERCENT:  cur_mix    = val;
            scsf_pkg::REG_WIDE_SAMPLES: cur_wide   = val[0];
            scsf_pkg::REG_STEREO_OUT:   cur_stereo = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [6:0] mix, input logic wide, input logic stereo);
        write_reg(scsf_pkg::REG_MIX_PERCENT, mix);
        write_reg(scsf_pkg::REG_WIDE_SAMPLES, {6'd0, wide});
        write_reg(scsf_pkg::REG_STEREO_OUT, {6'd0, stereo});
        settings_count++;
    endtask

    // Wait until every pair is out and every sample is back.
    task automatic drain_pipeline();
        do @(negedge aclk);
        while (pair_queue.size() != 0 || s_tvalid || expected_samples.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [6:0] mix;
        logic       wide;
        logic       stereo;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // rail values and odd precisions under each output mode
        for (int d = 0; d < DIRECTED_SETS; d++) begin
            case (d)
                1: apply_setting(7'd100, 1'b0, 1'b1);
                2: apply_setting(7'd127, 1'b1, 1'b1);
                3: apply_setting(7'd1, 1'b1, 1'b0);
                4: apply_setting(7'd0, 1'b0, 1'b0);
                default: ;
            endcase
            @(negedge aclk);
            idle_on = 1'b1;
            for (int i = 0; i < DIRECTED_PAIRS; i++) pair_queue.push_back(directed_pair(i));
            drain_pipeline();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin mix = 7'd0;   wide = 1'b0; stereo = 1'b1; end
                1: begin mix = 7'd127; wide = 1'b0; stereo = 1'b1; end
                2: begin mix = 7'd50;  wide = 1'b1; stereo = 1'b0; end
                default: begin
                    mix    = $urandom_range(0, 1) ? edge_mix() : 7'($urandom_range(0, 127));
                    wide   = 1'($urandom_range(0, 1));
                    stereo = ($urandom_range(0, 3) != 0);
                end
            endcase
            // back-pressure phase: keep the sender busy so the block fills up
            if (ph == 3) stereo = 1'b1;
            apply_setting(mix, wide, stereo);
            @(negedge aclk);
            idle_on = !(ph == 3 || ph == 6);
            if (ph == 3) hold_req = hold_req + 1;
            for (int i = 0; i < PHASE_PAIRS; i++) pair_queue.push_back(random_pair());
            drain_pipeline();
        end

        repeat (8) @(posedge aclk);
        $display("Sent %0d sample pairs over %0d register settings, checked %0d samples.",
                 pairs_sent, settings_count, samples_checked);
        $display("Mismatches: %0d, samples still expected: %0d.",
                 error_count, expected_samples.size());
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("stereo_crossfeed_sample_formatter test passed");
        end else begin
            $display("stereo_crossfeed_sample_formatter test failed");
        end
        $finish;
    end

endmodule
